### hdl/ordered_palette_dither_top_assert.svh
// ----------------------------------------------------------------------------
// ordered_palette_dither_top assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef ORDERED_PALETTE_DITHER_TOP_ASSERT_SVH
`define ORDERED_PALETTE_DITHER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OPD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/opd_pkg.sv
// ----------------------------------------------------------------------------
// opd_pkg
// Shared constants, types and tables of the ordered palette dither block.
// ----------------------------------------------------------------------------
`default_nettype none

package opd_pkg;

  // Palette storage
  localparam int PALETTE_DEPTH = 64;
  localparam int IDX_W         = $clog2(PALETTE_DEPTH);
  localparam int WORD_W        = 32;

  // Configuration
  localparam int SIZE_W     = 7;
  localparam int SPREAD_W   = 10;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_ADDR_W = 1;

  // Stream widths
  localparam int IN_DATA_W  = 88;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 40;

  // Squared distance of three 8-bit channels fits 18 bits
  localparam int DIST_W = 18;
  localparam logic [DIST_W-1:0] BEST_INIT = {DIST_W{1'b1}};

  // Bayer threshold center
  localparam logic signed [6:0] BAYER_CENTER = 7'sd32;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_PIXEL = 1'b1
  } req_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_PALETTE_SIZE  = 1'b0,
    CFG_DITHER_SPREAD = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // Palette word handed to the distance unit
  typedef struct packed {
    logic              vld;
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] word;
  } dist_req_t;

  // Registered distance unit result
  typedef struct packed {
    logic              vld;
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] sq_dist;
    logic [WORD_W-1:0] word;
  } dist_res_t;

  // 8x8 Bayer thresholds, indexed by {row, column}
  localparam logic [5:0] BAYER_THR [0:63] = '{
    6'd0,  6'd32, 6'd8,  6'd40, 6'd2,  6'd34, 6'd10, 6'd42,
    6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26,
    6'd12, 6'd44, 6'd4,  6'd36, 6'd14, 6'd46, 6'd6,  6'd38,
    6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22,
    6'd3,  6'd35, 6'd11, 6'd43, 6'd1,  6'd33, 6'd9,  6'd41,
    6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25,
    6'd15, 6'd47, 6'd7,  6'd39, 6'd13, 6'd45, 6'd5,  6'd37,
    6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21
  };

endpackage

`default_nettype wire

### hdl/opd_ram.sv
// ----------------------------------------------------------------------------
// opd_ram
// Generic single-port RAM, one write or one read per cycle, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module opd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

### hdl/opd_dist.sv
// ----------------------------------------------------------------------------
// opd_dist
// Shared distance unit: squared RGB distance from the cell center to one
// palette word per cycle, result registered with its index and word.
// ----------------------------------------------------------------------------
`default_nettype none

module opd_dist import opd_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire rgb_t      center,
  input  wire dist_req_t req,
  output dist_res_t      res
);

  logic signed [8:0]  dr, dg, db;
  logic signed [17:0] sq_r, sq_g, sq_b;
  logic [DIST_W-1:0]  sum;

  // Channel differences, squares and sum
  always_comb begin
    dr   = $signed({1'b0, center.r}) - $signed({1'b0, req.word[7:0]});
    dg   = $signed({1'b0, center.g}) - $signed({1'b0, req.word[15:8]});
    db   = $signed({1'b0, center.b}) - $signed({1'b0, req.word[23:16]});
    sq_r = dr * dr;
    sq_g = dg * dg;
    sq_b = db * db;
    sum  = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res.vld <= 1'b0;
    end else begin
      res.vld <= req.vld;
    end
    res.idx     <= req.idx;
    res.sq_dist <= sum;
    res.word    <= req.word;
  end

endmodule

`default_nettype wire

### hdl/ordered_palette_dither_top.sv
// Pixel beat: bias, cell center, search of n entries (1..64), drain, then out_tvalid rises.
// in_tready returns with that result, so a new pixel is taken only once the last is done.
// Palette write beat: writes may be accepted back to back.
// The pace is one palette RAM read per cycle through the single distance unit.
// Reset (rst_n low, synchronous) clears control, palette_size to 1, dither_spread to 0;
// palette words are undefined until written.
// ----------------------------------------------------------------------------
// ordered_palette_dither_top
// Bayer 8x8 ordered dither onto a palette of up to 64 RGBA words with a
// sequenced nearest-color search and optional coverage blend.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_palette_dither_top import opd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Configuration write port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  // Input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // tdata from bit 0: entry_index(6) entry_color(32) column_phase(3) row_phase(3)
  //   pixel_red(8) pixel_green(8) pixel_blue(8) pixel_alpha(8) masked_mode(1)
  //   coverage(8), zero fill to 88
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // tuser from bit 0: req_type(1)
  input  wire logic [IN_USER_W-1:0]  in_tuser,
  // Result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // tdata from bit 0: out_red(8) out_green(8) out_blue(8) out_alpha(8)
  //   chosen_entry(6), zero fill to 40
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BIAS,
    S_CENTER,
    S_SEARCH,
    S_DRAIN,
    S_FINISH
  } state_t;

  // Registers
  state_t                state_r, state_nxt;
  logic [SIZE_W-1:0]     size_r, size_nxt;
  logic [SPREAD_W-1:0]   spread_r, spread_nxt;
  logic [IDX_W-1:0]      cnt_r, cnt_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic                  out_vld_r, out_vld_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  // Pixel payload
  logic [2:0]            col_r, col_nxt;
  logic [2:0]            row_r, row_nxt;
  rgb_t                  pix_r, pix_nxt;
  logic [7:0]            alpha_r, alpha_nxt;
  logic                  masked_r, masked_nxt;
  logic [7:0]            cov_r, cov_nxt;
  logic signed [10:0]    bias_r, bias_nxt;
  rgb_t                  center_r, center_nxt;
  logic [DIST_W-1:0]     best_dist_r, best_dist_nxt;
  logic [IDX_W-1:0]      best_idx_r, best_idx_nxt;
  logic [WORD_W-1:0]     best_word_r, best_word_nxt;

  // Datapath wires
  logic                  in_acc;
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_addr;
  logic [WORD_W-1:0]     ram_rdata;
  logic [IDX_W-1:0]      last_idx;
  logic signed [6:0]     thr_c;
  logic signed [17:0]    bias_prod;
  logic signed [17:0]    bias_sh;
  dist_req_t             dreq;
  dist_res_t             dres;

  // Bias add and clamp to a byte
  function automatic logic [7:0] clamp_add(input logic [7:0] p, input logic signed [10:0] b);
    logic signed [11:0] s;
    s = $signed({4'b0000, p}) + $signed({b[10], b});
    if (s < 0) begin
      return 8'd0;
    end else if (s > 12'sd255) begin
      return 8'd255;
    end else begin
      return s[7:0];
    end
  endfunction

  // p + floor((n - p) * cov / 256)
  function automatic logic [7:0] blend(input logic [7:0] p, input logic [7:0] n,
                                       input logic [7:0] cov);
    logic signed [8:0]  diff;
    logic signed [17:0] prod;
    logic signed [17:0] sh;
    logic [9:0]         sum;
    diff = $signed({1'b0, n}) - $signed({1'b0, p});
    prod = diff * $signed({1'b0, cov});
    sh   = prod >>> 8;
    sum  = {2'b00, p} + sh[9:0];
    return sum[7:0];
  endfunction

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // Palette write from a write beat; otherwise the search address
  assign ram_we   = in_acc && (req_t'(in_tuser[0]) == REQ_WRITE) &&
                    (32'(in_tdata[5:0]) < PALETTE_DEPTH);
  assign ram_addr = (state_r == S_SEARCH) ? cnt_r : IDX_W'(in_tdata[5:0]);

  opd_ram #(
    .WIDTH (WORD_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_tdata[37:6]),
    .rdata (ram_rdata)
  );

  // Read data goes to the distance unit the cycle after its address
  assign dreq.vld  = rd_vld_r;
  assign dreq.idx  = rd_idx_r;
  assign dreq.word = ram_rdata;

  opd_dist u_dist (
    .clk    (clk),
    .rst_n  (rst_n),
    .center (center_r),
    .req    (dreq),
    .res    (dres)
  );

  // Last entry searched: zero counts as one, above depth counts as depth
  always_comb begin
    if (size_r == '0) begin
      last_idx = '0;
    end else if (32'(size_r) > PALETTE_DEPTH) begin
      last_idx = IDX_W'(PALETTE_DEPTH - 1);
    end else begin
      last_idx = IDX_W'(size_r - 1'b1);
    end
  end

  // Bayer bias: floor((thr - 32) * spread / 64)
  always_comb begin
    thr_c     = $signed({1'b0, BAYER_THR[{row_r, col_r}]}) - BAYER_CENTER;
    bias_prod = thr_c * $signed({1'b0, spread_r});
    bias_sh   = bias_prod >>> 6;
  end

  // Sequencer and next-state logic
  always_comb begin
    state_nxt     = state_r;
    size_nxt      = size_r;
    spread_nxt    = spread_r;
    cnt_nxt       = cnt_r;
    rd_vld_nxt    = 1'b0;
    rd_idx_nxt    = cnt_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    out_data_nxt  = out_data_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    pix_nxt       = pix_r;
    alpha_nxt     = alpha_r;
    masked_nxt    = masked_r;
    cov_nxt       = cov_r;
    bias_nxt      = bias_r;
    center_nxt    = center_r;
    best_dist_nxt = best_dist_r;
    best_idx_nxt  = best_idx_r;
    best_word_nxt = best_word_r;

    // Configuration writes
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        CFG_PALETTE_SIZE:  size_nxt   = cfg_wdata[SIZE_W-1:0];
        CFG_DITHER_SPREAD: spread_nxt = cfg_wdata[SPREAD_W-1:0];
      endcase
    end

    // Running minimum, first index wins ties
    if (dres.vld && (dres.sq_dist < best_dist_r)) begin
      best_dist_nxt = dres.sq_dist;
      best_idx_nxt  = dres.idx;
      best_word_nxt = dres.word;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (req_t'(in_tuser[0]) == REQ_PIXEL)) begin
          col_nxt    = in_tdata[40:38];
          row_nxt    = in_tdata[43:41];
          pix_nxt.r  = in_tdata[51:44];
          pix_nxt.g  = in_tdata[59:52];
          pix_nxt.b  = in_tdata[67:60];
          alpha_nxt  = in_tdata[75:68];
          masked_nxt = in_tdata[76];
          cov_nxt    = in_tdata[84:77];
          state_nxt  = S_BIAS;
        end
      end
      S_BIAS: begin
        bias_nxt  = bias_sh[10:0];
        state_nxt = S_CENTER;
      end
      S_CENTER: begin
        // Clamped channel, then the center of its 16-wide cell
        center_nxt.r  = clamp_add(pix_r.r, bias_r);
        center_nxt.g  = clamp_add(pix_r.g, bias_r);
        center_nxt.b  = clamp_add(pix_r.b, bias_r);
        center_nxt.r  = {center_nxt.r[7:4], 4'h8};
        center_nxt.g  = {center_nxt.g[7:4], 4'h8};
        center_nxt.b  = {center_nxt.b[7:4], 4'h8};
        best_dist_nxt = BEST_INIT;
        cnt_nxt       = '0;
        state_nxt     = S_SEARCH;
      end
      S_SEARCH: begin
        // One palette read issued per cycle
        rd_vld_nxt = 1'b1;
        if (cnt_r == last_idx) begin
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DRAIN: begin
        if (!rd_vld_r && !dres.vld) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        // Load the output register once it is free
        if (!out_vld_r || out_tready) begin
          out_vld_nxt = 1'b1;
          out_data_nxt = '0;
          if (masked_r) begin
            out_data_nxt[7:0]   = blend(pix_r.r, best_word_r[7:0], cov_r);
            out_data_nxt[15:8]  = blend(pix_r.g, best_word_r[15:8], cov_r);
            out_data_nxt[23:16] = blend(pix_r.b, best_word_r[23:16], cov_r);
            out_data_nxt[31:24] = alpha_r;
          end else begin
            out_data_nxt[31:0]  = best_word_r;
          end
          out_data_nxt[37:32] = 6'(best_idx_r);
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      size_r    <= SIZE_W'(1);
      spread_r  <= '0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      size_r    <= size_nxt;
      spread_r  <= spread_nxt;
      rd_vld_r  <= rd_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
    cnt_r       <= cnt_nxt;
    rd_idx_r    <= rd_idx_nxt;
    out_data_r  <= out_data_nxt;
    col_r       <= col_nxt;
    row_r       <= row_nxt;
    pix_r       <= pix_nxt;
    alpha_r     <= alpha_nxt;
    masked_r    <= masked_nxt;
    cov_r       <= cov_nxt;
    bias_r      <= bias_nxt;
    center_r    <= center_nxt;
    best_dist_r <= best_dist_nxt;
    best_idx_r  <= best_idx_nxt;
    best_word_r <= best_word_nxt;
  end

endmodule

`default_nettype wire

### hdl/opd_checker.sv
// ----------------------------------------------------------------------------
// opd_checker
// Port-level checks of the ordered palette dither top, bound to every instance.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ordered_palette_dither_top_assert.svh"

module opd_checker import opd_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic [IN_USER_W-1:0]  in_tuser,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata
);

  // A stalled result beat stays valid
  `OPD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "out beat dropped while stalled")

  // A stalled result beat keeps its data
  `OPD_ASSERT_NEXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata), "out data changed while stalled")

  // A pixel beat starts the search: no new beat taken in the next cycle
  `OPD_ASSERT_NEXT(a_pixel_busy, clk, rst_n, in_tvalid && in_tready && (in_tuser[0] == REQ_PIXEL), !in_tready, "input ready right after a pixel beat")

  // No result can follow an accepted beat in the next cycle
  `OPD_ASSERT_NEXT(a_no_early_out, clk, rst_n, in_tvalid && in_tready, !$rose(out_tvalid), "result appeared too soon after an input beat")

endmodule

bind ordered_palette_dither_top opd_checker u_opd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

### sim/testbench.sv
// ----------------------------------------------------------------------------
// ordered_palette_dither_top testbench
// Loads palettes through the input stream, dithers pixels under a series of
// spread and palette size settings, and checks every result beat against a
// local nearest-entry search with random stalls on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import opd_pkg::*;

  // One input beat, all fields unpacked
  typedef struct {
    req_t       kind;
    logic [5:0] slot;
    logic [31:0] color;
    logic [2:0] col;
    logic [2:0] row;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       masked;
    logic [7:0] cov;
  } dither_req_t;

  // Result beat, laid out as out_tdata[37:0]
  typedef struct packed {
    logic [5:0] entry;
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } dither_out_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // Local copy of the block state
  logic [31:0]   pal_words [PALETTE_DEPTH];
  logic [6:0]    pal_size_reg;
  int            spread_val;
  dither_out_t   pending_pixels [$];

  int mismatches;
  int n_writes;
  int n_pixels;
  int n_settings;
  int result_beats;
  bit steady;
  int ready_hold;

  ordered_palette_dither_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Run did not finish in time");
    $display("Mismatches found");
    $finish;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // 8x8 Bayer value from bit interleave of (row ^ col) and row
  function automatic int bayer_value(logic [2:0] row, logic [2:0] col);
    logic [2:0] a;
    a = row ^ col;
    return int'({a[0], row[0], a[1], row[1], a[2], row[2]});
  endfunction

  function automatic logic [7:0] clamp_channel(int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  // Blend toward the palette channel by cov/256, rounding toward minus infinity
  function automatic logic [7:0] ease_channel(logic [7:0] p, logic [7:0] t, logic [7:0] cov);
    int step;
    step = ((int'(t) - int'(p)) * int'(cov)) >>> 8;
    return 8'(int'(p) + step);
  endfunction

  // Expected result of one pixel under the current palette and registers
  function automatic dither_out_t dither_pixel(dither_req_t rq);
    int          bias;
    int          cr, cg, cb;
    int          dr, dg, db;
    int          n, i, d, best_d;
    logic [5:0]  best;
    logic [31:0] w;
    dither_out_t res;
    bias = ((bayer_value(rq.row, rq.col) - 32) * spread_val) >>> 6;
    // center of the 16-wide cell holding each biased channel
    cr = int'({clamp_channel(int'(rq.red) + bias) & 8'hf0}) | 8;
    cg = int'({clamp_channel(int'(rq.green) + bias) & 8'hf0}) | 8;
    cb = int'({clamp_channel(int'(rq.blue) + bias) & 8'hf0}) | 8;
    n = int'(pal_size_reg);
    if (n < 1) n = 1;
    if (n > PALETTE_DEPTH) n = PALETTE_DEPTH;
    best = '0;
    best_d = 32'h7fffffff;
    for (i = 0; i < n; i++) begin
      w = pal_words[i];
      dr = cr - int'(w[7:0]);
      dg = cg - int'(w[15:8]);
      db = cb - int'(w[23:16]);
      d = dr * dr + dg * dg + db * db;
      // strict less-than: first index wins a tie
      if (d < best_d) begin
        best_d = d;
        best = i[5:0];
      end
    end
    w = pal_words[best];
    res.entry = best;
    if (rq.masked) begin
      res.red   = ease_channel(rq.red, w[7:0], rq.cov);
      res.green = ease_channel(rq.green, w[15:8], rq.cov);
      res.blue  = ease_channel(rq.blue, w[23:16], rq.cov);
      res.alpha = rq.alpha;
    end else begin
      res.red   = w[7:0];
      res.green = w[15:8];
      res.blue  = w[23:16];
      res.alpha = w[31:24];
    end
    return res;
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_req(dither_req_t rq);
    return {3'b000, rq.cov, rq.masked, rq.alpha, rq.blue, rq.green, rq.red,
            rq.row, rq.col, rq.color, rq.slot};
  endfunction

  // Channel values that lean toward the extremes
  function automatic logic [7:0] pick_channel();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'h00;
    if (r < 20) return 8'hff;
    return 8'($urandom_range(0, 255));
  endfunction

  // Palette word, often on a cell center so that ties and exact hits occur
  function automatic logic [31:0] pick_color();
    logic [31:0] c;
    c = $urandom;
    if ($urandom_range(0, 1)) c = (c & 32'hfff0f0f0) | 32'h00080808;
    return c;
  endfunction

  function automatic dither_req_t random_req();
    dither_req_t rq;
    rq.kind   = REQ_PIXEL;
    rq.slot   = 6'($urandom_range(0, 63));
    rq.color  = pick_color();
    rq.col    = 3'($urandom_range(0, 7));
    rq.row    = 3'($urandom_range(0, 7));
    rq.red    = pick_channel();
    rq.green  = pick_channel();
    rq.blue   = pick_channel();
    rq.alpha  = 8'($urandom_range(0, 255));
    rq.masked = 1'($urandom_range(0, 1));
    rq.cov    = pick_channel();
    return rq;
  endfunction

  function automatic dither_req_t make_write(logic [5:0] slot, logic [31:0] color);
    dither_req_t rq;
    rq = random_req();
    rq.kind  = REQ_WRITE;
    rq.slot  = slot;
    rq.color = color;
    return rq;
  endfunction

  function automatic dither_req_t make_pixel(logic [2:0] row, logic [2:0] col,
                                             logic [31:0] rgba, logic masked,
                                             logic [7:0] cov);
    dither_req_t rq;
    rq = random_req();
    rq.row    = row;
    rq.col    = col;
    rq.red    = rgba[7:0];
    rq.green  = rgba[15:8];
    rq.blue   = rgba[23:16];
    rq.alpha  = rgba[31:24];
    rq.masked = masked;
    rq.cov    = cov;
    return rq;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatches < 50)
      $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Send one beat; model state moves at the accepting edge
  task automatic send_req(input dither_req_t rq);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= pack_req(rq);
    in_tuser  <= rq.kind;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (rq.kind == REQ_WRITE) begin
      pal_words[rq.slot] = rq.color;
      n_writes++;
    end else begin
      pending_pixels.push_back(dither_pixel(rq));
      n_pixels++;
    end
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending, let all results return, then let the search unit settle
  task automatic wait_idle(input int settle);
    int guard;
    guard = 0;
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (settle) @(posedge clk);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] size_word,
                              input logic [CFG_DATA_W-1:0] spread_word);
    wait_idle(80);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_PALETTE_SIZE;
    cfg_wdata <= size_word;
    @(posedge clk);
    pal_size_reg = size_word[6:0];
    cfg_addr  <= CFG_DITHER_SPREAD;
    cfg_wdata <= spread_word;
    @(posedge clk);
    spread_val = int'(spread_word);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // Reset values: one entry searched, no dither
  task automatic test_reset_defaults();
    send_req(make_write(6'd0, 32'h7f40c020));
    send_req(make_pixel(3'd7, 3'd0, 32'hffffffff, 1'b0, 8'h00));
    send_req(make_pixel(3'd0, 3'd0, 32'h00000000, 1'b1, 8'hff));
    send_req(make_pixel(3'd3, 3'd5, 32'h12345678, 1'b1, 8'h80));
  endtask

  // Small palette: exact hit, tie between equal entries, blend extremes
  task automatic test_search_and_blend();
    program_regs(10'd4, 10'd0);
    send_req(make_write(6'd0, 32'hff000000));
    send_req(make_write(6'd1, 32'h80ffffff));
    send_req(make_write(6'd2, 32'h12ffffff));  // same color as entry 1
    send_req(make_write(6'd3, 32'h3c888888));
    send_req(make_pixel(3'd0, 3'd0, 32'h00000000, 1'b0, 8'h00));
    send_req(make_pixel(3'd1, 3'd2, 32'h00ffffff, 1'b0, 8'h00));
    send_req(make_pixel(3'd4, 3'd4, 32'h5a808080, 1'b1, 8'hff));
    send_req(make_pixel(3'd6, 3'd1, 32'ha5808080, 1'b1, 8'h00));
    send_req(make_pixel(3'd2, 3'd7, 32'hc3ff00ff, 1'b1, 8'h80));
  endtask

  // Full spread: bias at both ends drives channels into the clamps
  task automatic test_dither_extremes();
    program_regs(10'd4, 10'd1023);
    send_req(make_pixel(3'd0, 3'd0, 32'h00ffffff, 1'b0, 8'h00));
    send_req(make_pixel(3'd7, 3'd0, 32'h00000000, 1'b0, 8'h00));
    send_req(make_pixel(3'd7, 3'd4, 32'hff7f7f7f, 1'b1, 8'hc0));
  endtask

  // Size of zero, above the depth, and with stray upper data bits
  task automatic test_size_edges();
    int i;
    program_regs(10'd0, 10'd0);
    send_req(make_pixel(3'd1, 3'd1, 32'h40ffffff, 1'b0, 8'h00));
    for (i = 0; i < PALETTE_DEPTH - 1; i++)
      send_req(make_write(6'(i), $urandom & 32'hfff0f0f0));
    // only the last entry sits exactly on a cell center
    send_req(make_write(6'd63, 32'h77d838a8));
    program_regs(10'd127, 10'd0);
    send_req(make_pixel(3'd2, 3'd2, 32'h00d030a0, 1'b0, 8'h00));
    program_regs(10'h3c8, 10'd200);
    send_req(make_pixel(3'd5, 3'd3, 32'h11d535a5, 1'b1, 8'h40));
    program_regs(10'd64, 10'd0);
    send_req(make_pixel(3'd0, 3'd6, 32'h00dc3cac, 1'b0, 8'h00));
    program_regs(10'd63, 10'd0);
    send_req(make_pixel(3'd0, 3'd6, 32'h00dc3cac, 1'b0, 8'h00));
    program_regs(10'd65, 10'd0);
    send_req(make_pixel(3'd0, 3'd6, 32'h00dc3cac, 1'b1, 8'hff));
  endtask

  // Mixed palette updates and pixels over several register settings
  task automatic test_random_traffic();
    int ph, k;
    logic [CFG_DATA_W-1:0] sz, sp;
    dither_req_t rq;
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin sz = 10'd64; sp = 10'd1023; end
        1: begin sz = 10'd2; sp = 10'd0; end
        2: begin sz = 10'($urandom_range(3, 64)); sp = 10'($urandom_range(0, 1023)); end
        3: begin sz = 10'd127; sp = 10'($urandom_range(0, 1023)); end
        4: begin sz = 10'd16; sp = 10'd1023; end
        5: begin sz = 10'($urandom_range(1, 64)); sp = 10'd1; end
        6: begin sz = 10'd64; sp = 10'($urandom_range(0, 1023)); end
        default: begin sz = 10'($urandom_range(0, 127)); sp = 10'd64; end
      endcase
      steady = (ph == 3 || ph == 6);
      program_regs(sz, sp);
      for (k = 0; k < 150; k++) begin
        rq = random_req();
        if ($urandom_range(0, 99) < 15) rq.kind = REQ_WRITE;
        send_req(rq);
      end
    end
    steady = 1'b0;
  endtask

  // Result sink with random back-pressure
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold = ready_hold - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      ready_hold = pick_gap();
    end
  end

  // Compare each result beat with the oldest expected pixel
  always @(posedge clk) begin : check_result
    dither_out_t seen, want;
    if (rst_n && out_tvalid && out_tready) begin
      seen = out_tdata[37:0];
      result_beats++;
      if (pending_pixels.size() == 0) begin
        report_mismatch("result beat with no pixel pending", seen, 0);
      end else begin
        want = pending_pixels.pop_front();
        if (seen.red != want.red)
          report_mismatch($sformatf("beat %0d red", result_beats), seen.red, want.red);
        if (seen.green != want.green)
          report_mismatch($sformatf("beat %0d green", result_beats), seen.green, want.green);
        if (seen.blue != want.blue)
          report_mismatch($sformatf("beat %0d blue", result_beats), seen.blue, want.blue);
        if (seen.alpha != want.alpha)
          report_mismatch($sformatf("beat %0d alpha", result_beats), seen.alpha, want.alpha);
        if (seen.entry != want.entry)
          report_mismatch($sformatf("beat %0d entry", result_beats), seen.entry, want.entry);
      end
    end
  end

  initial begin
    mismatches   = 0;
    n_writes     = 0;
    n_pixels     = 0;
    n_settings   = 0;
    result_beats = 0;
    steady       = 1'b0;
    ready_hold   = 0;
    pal_size_reg = 7'd1;
    spread_val   = 0;
    for (int i = 0; i < PALETTE_DEPTH; i++) pal_words[i] = '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_search_and_blend();
    test_dither_extremes();
    test_size_edges();
    test_random_traffic();

    wait_idle(80);
    if (pending_pixels.size() != 0)
      report_mismatch("pixels still waiting for a result", pending_pixels.size(), 0);

    $display("Covered %0d palette writes and %0d pixels over %0d register settings",
             n_writes, n_pixels, n_settings);
    $display("Checked %0d result beats", result_beats);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
